>>> src/dq_pkg.sv
`default_nettype none

package dq_pkg;

   // Storage geometry
   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 64;
   localparam int IDX_WIDTH  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

   // Fixed field widths of the channels
   localparam int VALUE_WIDTH = 64;
   localparam int COUNT_WIDTH = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_BACK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_PUSH_FULL  = 2'd1,
      STATUS_POP_EMPTY  = 2'd2,
      STATUS_RESERVED   = 2'd3
   } status_type;

   typedef struct packed {
      op_type                   operation;
      logic [VALUE_WIDTH-1:0]   value;
   } req_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0]   front_word;
      logic [VALUE_WIDTH-1:0]   back_word;
      logic [COUNT_WIDTH-1:0]   entry_count;
      logic                     is_empty;
      logic                     is_full;
      status_type               status;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/dq_req_if.sv
`default_nettype none

interface dq_req_if;
   logic             valid;
   logic             ready;
   dq_pkg::req_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/dq_rsp_if.sv
`default_nettype none

interface dq_rsp_if;
   logic             valid;
   logic             ready;
   dq_pkg::rsp_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> src/dq_ram.sv
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry with a registered output
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/double_ended_queue.sv
// Bounded deque over a ring of slots in one synchronous RAM (one write, one read port).
// A push or rejected operation goes from ST_IDLE to ST_DONE; a successful pop goes
// through ST_READ first (for the RAM read). ST_DONE loads the registered response
// once the output register is free, so rsp back-pressure stalls it; no new request
// is accepted until the state returns to ST_IDLE.
// Reset clears pointers, count and handshake state; slot contents stay undefined.
`default_nettype none

module double_ended_queue (
   input  wire logic  clock,
   input  wire logic  reset,
   dq_req_if.sink     req_ch,
   dq_rsp_if.source   rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   localparam int IW = dq_pkg::IDX_WIDTH;
   localparam int CW = dq_pkg::CNT_WIDTH;
   localparam int WW = dq_pkg::WORD_WIDTH;

   // Control state
   state_type              state_ff,     state_in;
   logic [IW-1:0]          head_ff,      head_in;
   logic [IW-1:0]          tail_ff,      tail_in;
   logic [CW-1:0]          count_ff,     count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [WW-1:0]          front_ff,     front_in;
   logic [WW-1:0]          back_ff,      back_in;
   logic                   to_front_ff,  to_front_in;
   dq_pkg::status_type     status_ff,    status_in;
   dq_pkg::rsp_type        rsp_ff,       rsp_in;

   // RAM port
   logic                   wr_en;
   logic [IW-1:0]          wr_addr;
   logic                   rd_en;
   logic [IW-1:0]          rd_addr;
   logic [WW-1:0]          rd_data;

   // Ring neighbors
   logic [IW-1:0]          head_prev, head_next, tail_prev, tail_next, tail_prev2;
   logic                   is_full_now, is_empty_now, accept;
   logic [WW-1:0]          word;

   assign head_prev  = (head_ff == '0) ? IW'(dq_pkg::DEPTH - 1) : head_ff - IW'(1);
   assign head_next  = (head_ff == IW'(dq_pkg::DEPTH - 1)) ? '0 : head_ff + IW'(1);
   assign tail_prev  = (tail_ff == '0) ? IW'(dq_pkg::DEPTH - 1) : tail_ff - IW'(1);
   assign tail_next  = (tail_ff == IW'(dq_pkg::DEPTH - 1)) ? '0 : tail_ff + IW'(1);
   assign tail_prev2 = (tail_prev == '0) ? IW'(dq_pkg::DEPTH - 1) : tail_prev - IW'(1);

   assign is_full_now  = (count_ff == CW'(dq_pkg::DEPTH));
   assign is_empty_now = (count_ff == '0);
   assign word         = req_ch.payload.value[WW-1:0];
   assign accept       = req_ch.valid && req_ch.ready;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   dq_ram #(
      .WIDTH (WW),
      .DEPTH (dq_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // One transaction: update pointers (and a push's ends), read a pop's new end, respond
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      to_front_in  = to_front_ff;
      status_in    = status_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = head_prev;
      rd_en        = 1'b0;
      rd_addr      = head_next;

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               status_in = dq_pkg::STATUS_DONE;
               state_in  = ST_DONE;
               case (req_ch.payload.operation)
                  dq_pkg::OP_PUSH_FRONT: begin
                     if (is_full_now) begin
                        status_in = dq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        head_in  = head_prev;
                        wr_en    = 1'b1;
                        wr_addr  = head_prev;
                        count_in = count_ff + CW'(1);
                        front_in = word;
                        if (is_empty_now) begin
                           back_in = word;
                        end
                     end
                  end
                  dq_pkg::OP_PUSH_BACK: begin
                     if (is_full_now) begin
                        status_in = dq_pkg::STATUS_PUSH_FULL;
                     end else begin
                        tail_in  = tail_next;
                        wr_en    = 1'b1;
                        wr_addr  = tail_ff;
                        count_in = count_ff + CW'(1);
                        back_in  = word;
                        if (is_empty_now) begin
                           front_in = word;
                        end
                     end
                  end
                  dq_pkg::OP_POP_FRONT: begin
                     if (is_empty_now) begin
                        status_in = dq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        head_in     = head_next;
                        count_in    = count_ff - CW'(1);
                        rd_en       = 1'b1;
                        rd_addr     = head_next;
                        to_front_in = 1'b1;
                        state_in    = ST_READ;
                     end
                  end
                  default: begin
                     if (is_empty_now) begin
                        status_in = dq_pkg::STATUS_POP_EMPTY;
                     end else begin
                        tail_in     = tail_prev;
                        count_in    = count_ff - CW'(1);
                        rd_en       = 1'b1;
                        rd_addr     = tail_prev2;
                        to_front_in = 1'b0;
                        state_in    = ST_READ;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            // Capture the newly exposed end word
            if (to_front_ff) begin
               front_in = rd_data;
            end else begin
               back_in = rd_data;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Load the output register when it is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in.front_word  = is_empty_now ? '0 : dq_pkg::VALUE_WIDTH'(front_ff);
               rsp_in.back_word   = is_empty_now ? '0 : dq_pkg::VALUE_WIDTH'(back_ff);
               rsp_in.entry_count = dq_pkg::COUNT_WIDTH'(count_ff);
               rsp_in.is_empty    = is_empty_now;
               rsp_in.is_full     = is_full_now;
               rsp_in.status      = status_ff;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      front_ff    <= front_in;
      back_ff     <= back_in;
      to_front_ff <= to_front_in;
      status_ff   <= status_in;
      rsp_ff      <= rsp_in;
   end

endmodule

`default_nettype wire
